@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the RTL of this block.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/core/cea_pkg.sv @@
`default_nettype none

package cea_pkg;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned TOT_W   = 32;
  localparam int unsigned DT_W    = 32;
  localparam int unsigned AMAG_W  = 16;
  localparam int unsigned VOLT_W  = 15;
  localparam int unsigned VA_W    = VOLT_W + AMAG_W;
  localparam int unsigned CPROD_W = AMAG_W + DT_W;
  localparam int unsigned EPROD_W = VA_W + DT_W;

  // Division sequence: reciprocal estimate, back multiply, subtract and
  // three corrections; both lanes step together.
  localparam int unsigned DIV_STEPS = 6;
  localparam int unsigned Q_W       = 28;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] DIV_RECIP = CNT_W'(0);
  localparam logic [CNT_W-1:0] DIV_BACK  = CNT_W'(1);
  localparam logic [CNT_W-1:0] DIV_SUB   = CNT_W'(2);

  localparam int unsigned CREM_W = 29;
  localparam int unsigned EREM_W = 36;
  localparam int unsigned CX_W   = 48;
  localparam int unsigned EX_W   = 63;

  // Top bits of each sum feed the reciprocal multiply.
  localparam int unsigned XH_W   = 32;
  localparam int unsigned RCP_SH = 32;
  localparam int unsigned RC_W   = 20;
  localparam int unsigned RE_W   = 28;

  localparam logic [63:0] CHARGE_DIV = 64'd360000000;
  localparam logic [63:0] ENERGY_DIV = 64'd36000000000;
  localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

  localparam logic [RC_W-1:0] CHARGE_RECIP =
    RC_W'((64'd1 << (CX_W - XH_W + RCP_SH)) / CHARGE_DIV);
  localparam logic [RE_W-1:0] ENERGY_RECIP =
    RE_W'((64'd1 << (EX_W - XH_W + RCP_SH)) / ENERGY_DIV);

  typedef enum logic [1:0] {
    KIND_RESET,
    KIND_START,
    KIND_HOLD,
    KIND_ACC
  } kind_e;

  typedef struct packed {
    logic load;
    logic decode;
    logic mul1;
    logic mul2;
    logic sum;
    logic div_step;
    logic commit;
    logic out_load;
  } cea_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  div_last;
    logic  out_free;
  } cea_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/cea_in_if.sv @@
`default_nettype none

interface cea_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [63:0]              time_us;
  logic signed [15:0]       volt_centi;
  logic signed [15:0]       amp_centi;

  modport source (output valid, mode, time_us, volt_centi, amp_centi, input ready);
  modport sink   (input valid, mode, time_us, volt_centi, amp_centi, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cea_out_if.sv @@
`default_nettype none

interface cea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] charge_mah;
  logic [31:0] energy_mwh;
  logic [63:0] elapsed_us;

  modport source (output valid, charge_mah, energy_mwh, elapsed_us, input ready);
  modport sink   (input valid, charge_mah, energy_mwh, elapsed_us, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cea_ctrl.sv @@
`default_nettype none

module cea_ctrl
  import cea_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output cea_cmd_t      cmd_o,
  input  wire cea_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_DIV,
    S_COMMIT,
    S_OUTPUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = (sts_i.kind == KIND_ACC) ? S_MUL2 : S_COMMIT;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_OUTPUT;
      end
      S_OUTPUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/cea_dp.sv @@
`default_nettype none

`include "assert_macros.svh"

module cea_dp
  import cea_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               mode_i,
  input  wire logic [TIME_W-1:0]  time_us_i,
  input  wire logic [SMP_W-1:0]   volt_centi_i,
  input  wire logic [SMP_W-1:0]   amp_centi_i,
  input  wire cea_cmd_t           cmd_i,
  output cea_sts_t                sts_o,
  cea_out_if.source               out_o
);

  // Captured item
  logic               mode_q;
  logic [TIME_W-1:0]  t_q;
  logic [VOLT_W-1:0]  volt_q;
  logic [AMAG_W-1:0]  amag_q;

  // Work registers
  kind_e              kind_q;
  logic [DT_W-1:0]    dt_q;
  logic [CPROD_W-1:0] cprod_q;
  logic [VA_W-1:0]    va_q;
  logic [EPROD_W-1:0] eprod_q;
  logic [CX_W-1:0]    cx_q, cqd_q;
  logic [EX_W-1:0]    ex_q, eqd_q;
  logic [Q_W-1:0]     cq_q, eq_q;
  logic [CNT_W-1:0]   cnt_q;

  // Accumulator state
  logic [TIME_W-1:0]  start_q, last_q;
  logic [TOT_W-1:0]   ctot_q, etot_q;
  logic [CREM_W-1:0]  crem_q;
  logic [EREM_W-1:0]  erem_q;

  logic               out_valid_q;

  logic [TIME_W-1:0]  diff;
  logic               started;
  logic [TOT_W-1:0]   cq_ext, eq_ext;
  logic [TIME_W-1:0]  elapsed;
  logic [XH_W+RC_W-1:0] cq_est;
  logic [XH_W+RE_W-1:0] eq_est;

  assign diff    = t_q - last_q;
  assign started = (start_q != '0) && (last_q != '0);
  assign cq_ext  = {{(TOT_W - Q_W){1'b0}}, cq_q};
  assign eq_ext  = {{(TOT_W - Q_W){1'b0}}, eq_q};
  assign elapsed = ((start_q == '0) || (last_q < start_q)) ? '0 : (last_q - start_q);
  assign cq_est  = (XH_W+RC_W)'(cx_q[CX_W-1 -: XH_W]) * (XH_W+RC_W)'(CHARGE_RECIP);
  assign eq_est  = (XH_W+RE_W)'(ex_q[EX_W-1 -: XH_W]) * (XH_W+RE_W)'(ENERGY_RECIP);

  // Item capture and arithmetic pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      t_q    <= time_us_i;
      volt_q <= volt_centi_i[SMP_W-1] ? '0 : volt_centi_i[VOLT_W-1:0];
      amag_q <= amp_centi_i[SMP_W-1] ? (~amp_centi_i + 1'b1) : amp_centi_i;
    end
    if (cmd_i.decode) begin
      if (mode_q) begin
        kind_q <= KIND_RESET;
      end else if (!started) begin
        kind_q <= KIND_START;
      end else if (t_q > last_q) begin
        kind_q <= KIND_ACC;
      end else begin
        kind_q <= KIND_HOLD;
      end
      dt_q <= (diff[TIME_W-1:DT_W] != '0) ? '1 : diff[DT_W-1:0];
    end
    if (cmd_i.mul1) begin
      cprod_q <= CPROD_W'(amag_q) * CPROD_W'(dt_q);
      va_q    <= VA_W'(volt_q) * VA_W'(amag_q);
    end
    if (cmd_i.mul2) begin
      eprod_q <= EPROD_W'(va_q) * EPROD_W'(dt_q);
    end
    if (cmd_i.sum) begin
      cx_q   <= CX_W'(crem_q) + CX_W'(cprod_q);
      ex_q   <= EX_W'(erem_q) + EX_W'(eprod_q);
      cq_q   <= '0;
      eq_q   <= '0;
      cnt_q  <= '0;
    end
    // Estimate each quotient from a reciprocal (at most three low), take
    // quotient times divisor off the sum, then correct one step at a time.
    // The remainder is left in cx_q/ex_q.
    if (cmd_i.div_step) begin
      unique case (cnt_q)
        DIV_RECIP: begin
          cq_q <= Q_W'(cq_est >> RCP_SH);
          eq_q <= Q_W'(eq_est >> RCP_SH);
        end
        DIV_BACK: begin
          cqd_q <= CX_W'(cq_q) * CX_W'(CHARGE_DIV);
          eqd_q <= EX_W'(eq_q) * EX_W'(ENERGY_DIV);
        end
        DIV_SUB: begin
          cx_q <= cx_q - cqd_q;
          ex_q <= ex_q - eqd_q;
        end
        default: begin
          if (cx_q >= CX_W'(CHARGE_DIV)) begin
            cx_q <= cx_q - CX_W'(CHARGE_DIV);
            cq_q <= cq_q + 1'b1;
          end
          if (ex_q >= EX_W'(ENERGY_DIV)) begin
            ex_q <= ex_q - EX_W'(ENERGY_DIV);
            eq_q <= eq_q + 1'b1;
          end
        end
      endcase
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Accumulator state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      last_q      <= '0;
      ctot_q      <= '0;
      etot_q      <= '0;
      crem_q      <= '0;
      erem_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        unique case (kind_q)
          KIND_RESET: begin
            start_q <= t_q;
            last_q  <= t_q;
            ctot_q  <= '0;
            etot_q  <= '0;
            crem_q  <= '0;
            erem_q  <= '0;
          end
          KIND_START: begin
            start_q <= t_q;
            last_q  <= t_q;
          end
          KIND_HOLD: begin
          end
          KIND_ACC: begin
            last_q <= t_q;
            // A saturated total freezes its remainder.
            if (ctot_q != TOTAL_MAX) begin
              if ((cq_q != '0) && (cq_ext >= ~ctot_q)) begin
                ctot_q <= TOTAL_MAX;
                crem_q <= '0;
              end else begin
                ctot_q <= ctot_q + cq_ext;
                crem_q <= cx_q[CREM_W-1:0];
              end
            end
            if (etot_q != TOTAL_MAX) begin
              if ((eq_q != '0) && (eq_ext >= ~etot_q)) begin
                etot_q <= TOTAL_MAX;
                erem_q <= '0;
              end else begin
                etot_q <= etot_q + eq_ext;
                erem_q <= ex_q[EREM_W-1:0];
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_o.charge_mah <= ctot_q;
      out_o.energy_mwh <= etot_q;
      out_o.elapsed_us <= elapsed;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign sts_o.kind     = kind_q;
  assign sts_o.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign sts_o.out_free = !out_valid_q || out_o.ready;

  `ASSERT_PROP(a_crem_range, clk_i, rst_ni, 64'(crem_q) < CHARGE_DIV, "charge remainder out of range")
  `ASSERT_PROP(a_erem_range, clk_i, rst_ni, 64'(erem_q) < ENERGY_DIV, "energy remainder out of range")
  `ASSERT_NEVER(a_sat_rem, clk_i, rst_ni, ((ctot_q == TOTAL_MAX) && (crem_q != '0)) || ((etot_q == TOTAL_MAX) && (erem_q != '0)), "saturated total kept a remainder")
  `ASSERT_PROP(a_acc_mono, clk_i, rst_ni, cmd_i.commit && (kind_q == KIND_ACC) |=> (ctot_q >= $past(ctot_q)) && (etot_q >= $past(etot_q)), "totals decreased on accumulate")

endmodule

`default_nettype wire

@@ rtl/core/charge_energy_accumulator.sv @@
// Charge and energy accumulator (coulomb counter).
// Input channel in_i carries one sample item: mode, a microsecond timestamp, a
// signed bus voltage in centivolts and a signed current in centiamps. Mode 1
// restarts accumulation at the given time; mode 0 integrates |I|*dt and
// max(V,0)*|I|*dt into whole mAh and mWh totals that saturate at 2^32-1.
// Output channel out_o returns one result item per input item: both totals
// and the elapsed time since the start timestamp.
// An item that integrates passes decode, the two multiply stages, the sum,
// the six-step division by constants that turns both remainders into whole
// units (reciprocal estimate, back multiply, subtract and three correction
// steps, both lanes in parallel), commit and output; a restart, first sample
// or non-advancing sample goes from the first multiply to commit and output.
// A new item is accepted only once the last one is in the result register.
// Reset clears the timestamps, totals and remainders at once; the block is
// unstarted until a sample with a nonzero timestamp arrives.
// When the receiver stalls, the result register holds its item and one more
// item may be accepted and worked on; it waits for the register to empty.
`default_nettype none

module charge_energy_accumulator
  import cea_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cea_in_if.sink    in_i,
  cea_out_if.source out_o
);

  cea_cmd_t cmd;
  cea_sts_t sts;

  // Sequencer: walks one item through decode, multiply, divide and commit.
  cea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Datapath: sample capture, products, divider lanes, totals and result register.
  cea_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (in_i.mode),
    .time_us_i    (in_i.time_us),
    .volt_centi_i (in_i.volt_centi),
    .amp_centi_i  (in_i.amp_centi),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

@@ sim/tb_charge_energy_accumulator.sv @@
`default_nettype none

module tb_charge_energy_accumulator;

  // Sample modes carried by the one-bit mode field.
  localparam logic MODE_ACC     = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Scale factors: centiamp-microseconds per mAh and
  // centivolt-centiamp-microseconds per mWh.
  localparam logic [63:0] MAH_SCALE = 64'd360000000;
  localparam logic [63:0] MWH_SCALE = 64'd36000000000;
  localparam logic [31:0] TOTAL_CAP = 32'hFFFF_FFFF;
  localparam logic [63:0] DT_CAP    = 64'h0000_0000_FFFF_FFFF;

  localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S16_MIN = 16'sh8000;

  // Cycles to let pass once nothing is outstanding.
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [31:0] charge_mah;
    logic [31:0] energy_mwh;
    logic [63:0] elapsed_us;
  } totals_t;

  logic clk;
  logic rst_n;

  cea_in_if  in_if ();
  cea_out_if out_if ();

  charge_energy_accumulator dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Predictor state: timestamps, whole-unit totals and sub-unit remainders.
  logic [63:0] start_us;
  logic [63:0] last_us;
  logic [31:0] charge_mah;
  logic [31:0] energy_mwh;
  logic [63:0] charge_frac;
  logic [63:0] energy_frac;

  totals_t pending_totals[$];
  int      n_mismatch;
  logic    back_to_back;  // when set, neither side idles

  initial begin
    start_us     = '0;
    last_us      = '0;
    charge_mah   = '0;
    energy_mwh   = '0;
    charge_frac  = '0;
    energy_frac  = '0;
    n_mismatch   = 0;
    back_to_back = 1'b0;
  end

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Move whole units out of the remainder into a saturating total.
  // Once the total is pinned at its cap, leave the remainder alone.
  function automatic void carry_units(inout logic [31:0] total, inout logic [63:0] frac,
                                      input logic [63:0] add, input logic [63:0] scale);
    logic [63:0] whole;
    if (total == TOTAL_CAP) return;
    frac  = frac + add;
    whole = frac / scale;
    frac  = frac % scale;
    if (whole != 0) begin
      if (whole >= 64'(TOTAL_CAP - total)) begin
        total = TOTAL_CAP;
        frac  = '0;
      end else begin
        total = total + whole[31:0];
      end
    end
  endfunction

  // Advance the predictor by one accepted item and return the totals it shows.
  function automatic totals_t predict_totals(input logic m, input logic [63:0] t,
                                             input logic signed [15:0] v,
                                             input logic signed [15:0] a);
    logic [63:0] dt;
    logic [63:0] amag;
    logic [63:0] volt;
    int          vi;
    int          ai;
    totals_t     res;
    vi = v;
    ai = a;
    if (m == MODE_RESTART) begin
      start_us    = t;
      last_us     = t;
      charge_mah  = '0;
      energy_mwh  = '0;
      charge_frac = '0;
      energy_frac = '0;
    end else if (start_us == 0 || last_us == 0) begin
      // Not started yet: mark the start, integrate nothing.
      start_us = t;
      last_us  = t;
    end else if (t > last_us) begin
      dt = t - last_us;
      if (dt > DT_CAP) dt = DT_CAP;
      amag = (ai < 0) ? 64'(-ai) : 64'(ai);
      volt = (vi < 0) ? 64'd0 : 64'(vi);
      carry_units(charge_mah, charge_frac, amag * dt, MAH_SCALE);
      carry_units(energy_mwh, energy_frac, volt * amag * dt, MWH_SCALE);
      last_us = t;
    end
    res.charge_mah = charge_mah;
    res.energy_mwh = energy_mwh;
    res.elapsed_us = (start_us == 0 || last_us < start_us) ? 64'd0 : last_us - start_us;
    return res;
  endfunction

  // Drive one sample item, hold it until accepted, then record what it should show.
  // Valid stays high after acceptance so a zero gap gives back-to-back items.
  task automatic send_sample(input logic m, input logic [63:0] t,
                             input logic signed [15:0] v, input logic signed [15:0] a);
    int gap;
    int dice;
    dice = $urandom_range(0, 99);
    if (back_to_back || dice < 50) gap = 0;
    else if (dice < 90)            gap = $urandom_range(1, 3);
    else                           gap = $urandom_range(10, 60);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.time_us    <= t;
    in_if.volt_centi <= v;
    in_if.amp_centi  <= a;
    do @(posedge clk); while (!in_if.ready);
    pending_totals.push_back(predict_totals(m, t, v, a));
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_totals.size() != 0);
  endtask

  // Result side: check each accepted item against the oldest prediction,
  // then pick the next ready level. Mostly short stalls, now and then long ones.
  initial begin : result_side
    int unsigned hold_left;
    int          dice;
    totals_t     want;
    totals_t     got;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got.charge_mah = out_if.charge_mah;
        got.energy_mwh = out_if.energy_mwh;
        got.elapsed_us = out_if.elapsed_us;
        if (pending_totals.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("[%0t] unexpected result: charge=%0d energy=%0d elapsed=%0d",
                     $realtime, got.charge_mah, got.energy_mwh, got.elapsed_us);
        end else begin
          want = pending_totals.pop_front();
          if (got.charge_mah !== want.charge_mah || got.energy_mwh !== want.energy_mwh ||
              got.elapsed_us !== want.elapsed_us) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("[%0t] mismatch: charge %0d/%0d energy %0d/%0d elapsed %0d/%0d (exp/act)",
                       $realtime, want.charge_mah, got.charge_mah, want.energy_mwh,
                       got.energy_mwh, want.elapsed_us, got.elapsed_us);
          end
        end
      end
      if (back_to_back) begin
        out_if.ready <= 1'b1;
        hold_left = 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        dice = $urandom_range(0, 99);
        if (dice < 55) begin
          out_if.ready <= 1'b1;
          hold_left = $urandom_range(0, 6);
        end else if (dice < 92) begin
          out_if.ready <= 1'b0;
          hold_left = $urandom_range(0, 3);
        end else begin
          out_if.ready <= 1'b0;
          hold_left = $urandom_range(10, 80);
        end
      end
    end
  end

  // Unstarted block, first sample, stalled and backward time, field extremes.
  task automatic test_startup();
    send_sample(MODE_ACC, 64'd0, 16'sd100, 16'sd100);   // time zero keeps it unstarted
    send_sample(MODE_ACC, 64'd1000, S16_MAX, S16_MIN);  // first sample only marks start
    send_sample(MODE_ACC, 64'd1000, S16_MAX, S16_MIN);  // same time: no change
    send_sample(MODE_ACC, 64'd999, S16_MAX, S16_MIN);   // backward time: no change
    send_sample(MODE_ACC, 64'd3_601_000, S16_MAX, S16_MIN);
    send_sample(MODE_ACC, 64'd7_201_000, S16_MIN, S16_MAX);  // negative voltage counts as zero
    send_sample(MODE_ACC, 64'd9_000_000, 16'sd0, 16'sd0);
    send_sample(MODE_ACC, 64'd9_500_000, -16'sd1, -16'sd1);
    send_sample(MODE_ACC, 64'd9_500_001, 16'sd1, 16'sd1);
  endtask

  // Restart items clear everything and ignore voltage and current.
  task automatic test_restart();
    send_sample(MODE_RESTART, 64'hFFFF_FFFF_FFFF_FFFF, -16'sd1, -16'sd1);
    send_sample(MODE_ACC, 64'd0, S16_MAX, S16_MAX);
    send_sample(MODE_RESTART, 64'd0, S16_MAX, S16_MIN);   // restart at zero: unstarted
    send_sample(MODE_ACC, 64'd5, S16_MAX, S16_MAX);
    send_sample(MODE_ACC, 64'd500_000_005, S16_MAX, S16_MAX);
    send_sample(MODE_RESTART, 64'h8000_0000_0000_0000, 16'sd0, 16'sd0);
    send_sample(MODE_ACC, 64'h8000_0000_0000_0001, S16_MAX, S16_MIN);
  endtask

  // Gaps at, just past and far past the dt cap.
  task automatic test_long_gap();
    send_sample(MODE_RESTART, 64'd1, 16'sd0, 16'sd0);
    send_sample(MODE_ACC, last_us + DT_CAP, S16_MAX, S16_MIN);
    send_sample(MODE_ACC, last_us + DT_CAP + 64'd1, S16_MAX, S16_MIN);
    send_sample(MODE_ACC, 64'hFFFF_FFFF_FFFF_FFFF, S16_MAX, S16_MIN);
  endtask

  // Energy hits its cap after a few dozen maximal steps; keep going past it.
  task automatic test_energy_saturation();
    send_sample(MODE_RESTART, 64'd1, 16'sd0, 16'sd0);
    for (int i = 0; i < 40; i++)
      send_sample(MODE_ACC, last_us + 64'(DT_CAP), S16_MAX, S16_MIN);
  endtask

  // Maximal steps with both sides never idling, then a few random ones with idling.
  task automatic test_max_rate();
    logic signed [15:0] a;
    send_sample(MODE_RESTART, 64'd1, 16'sd0, 16'sd0);
    back_to_back = 1'b1;
    for (int i = 0; i < 24; i++) begin
      a = ($urandom_range(0, 3) == 0) ? S16_MAX : S16_MIN;
      send_sample(MODE_ACC, last_us + 64'h1_0000_0000, 16'($urandom), a);
    end
    back_to_back = 1'b0;
    for (int i = 0; i < 5; i++)
      send_sample(MODE_ACC, last_us + 64'($urandom), 16'($urandom), 16'($urandom));
    send_sample(MODE_RESTART, last_us, 16'($urandom), 16'($urandom));
  endtask

  // Mostly advancing samples with random content; some restarts, stalled or
  // backward times, long gaps and fully random timestamps.
  task automatic test_random_traffic(input int count);
    logic               m;
    logic [63:0]        t;
    logic signed [15:0] v;
    logic signed [15:0] a;
    int                 dice;
    for (int i = 0; i < count; i++) begin
      dice = $urandom_range(0, 99);
      m = MODE_ACC;
      v = 16'($urandom);
      a = 16'($urandom);
      if ($urandom_range(0, 7) == 0) v = ($urandom_range(0, 1) == 0) ? S16_MAX : S16_MIN;
      if ($urandom_range(0, 7) == 0) a = ($urandom_range(0, 1) == 0) ? S16_MAX : S16_MIN;
      if (dice < 4) begin
        m = MODE_RESTART;
        t = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) t = 64'($urandom_range(0, 3));
      end else if (dice < 8) begin
        t = {$urandom, $urandom};
      end else if (dice < 14) begin
        t = last_us - 64'($urandom_range(0, 1000));
      end else if (dice < 20) begin
        t = last_us + {$urandom_range(0, 15), $urandom};
      end else begin
        t = last_us + 64'($urandom_range(1, 2_000_000));
      end
      send_sample(m, t, v, a);
    end
  endtask

  initial begin : run_tests
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.mode       <= MODE_ACC;
    in_if.time_us    <= '0;
    in_if.volt_centi <= '0;
    in_if.amp_centi  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_startup();
    wait_drained();
    test_restart();
    wait_drained();
    test_long_gap();
    wait_drained();
    test_energy_saturation();
    wait_drained();
    test_max_rate();
    wait_drained();
    test_random_traffic(300);
    wait_drained();
    back_to_back = 1'b1;
    test_random_traffic(150);
    back_to_back = 1'b0;
    test_random_traffic(300);
    wait_drained();

    // Let any stray late result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    n_mismatch += pending_totals.size();
    if (n_mismatch == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Stop a hung run; a correct one finishes well inside this.
  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
